// File: hw/rtl/cis_pkg.sv
// Shared types, constants and the case-folding function for the
// case-insensitive substring search block. No dependencies.
`timescale 1ns / 1ps

package cis_pkg;

    // Byte range that folds to lower case, and the fold offset.
    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Result position width and its saturation value.
    localparam int          POS_W   = 16;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // Command codes of an input beat.
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // Per-cycle step controls from the top level to the datapath.
    typedef struct packed {
        logic pat_beat;   // a pattern byte is processed this cycle
        logic txt_beat;   // a text byte is processed this cycle
        logic last_beat;  // the processed byte carries the last mark
    } cis_ctl_t;

    // Pattern side status seen by the text side.
    typedef struct packed {
        logic restart;    // a new pattern starts; text state must clear
        logic overflow;   // the stored pattern was too long
    } cis_pat_status_t;

    // One result beat.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } cis_result_t;

    // ASCII upper case letters map to lower case, all else passes.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_FIRST && c <= UPPER_LAST)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/case_insensitive_substring_search.sv
// Case-insensitive first-occurrence substring search, top level.
// An accepted last text beat passes the input register, and its result beat is held in the result register.
// Throughput: 1 beat per cycle while the result side is not stalled; the single-pass window compare sets the rate.
// Reset: rst_n clears all control state, no pattern loaded, both sides empty.
// Uses cis_pkg, cis_pattern and cis_text.
`timescale 1ns / 1ps

module case_insensitive_substring_search #(
    parameter int              MAX_PATTERN = 16,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        command,
    input  logic [7:0]  char_value,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        found,
    output logic [15:0] position,
    output logic        pattern_overflow
);
    import cis_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic                     beat_valid_reg;
    logic                     cmd_reg;
    logic [7:0]               char_reg;
    logic                     last_reg;
    logic                     res_valid_reg;
    cis_result_t              res_reg;
    logic                     advance;
    logic                     fire;
    logic [7:0]               char_fold;
    cis_ctl_t                 ctl;
    cis_pat_status_t          status;
    logic [MAX_PATTERN*8-1:0] pat_flat;
    logic [LW-1:0]            pat_len;
    logic                     res_valid;
    cis_result_t              res;

    // The held beat moves on whenever the result register can take a beat.
    assign advance    = !res_valid_reg || result_ready;
    assign fire       = beat_valid_reg && advance;
    assign item_ready = !beat_valid_reg || advance;

    assign char_fold     = fold_case(char_reg);
    assign ctl.pat_beat  = fire && (cmd_reg == CMD_PATTERN);
    assign ctl.txt_beat  = fire && (cmd_reg == CMD_TEXT);
    assign ctl.last_beat = last_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            beat_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            cmd_reg  <= command;
            char_reg <= char_value;
            last_reg <= last;
        end
    end

    cis_pattern #(
        .MAX_PATTERN (MAX_PATTERN),
        .LW          (LW)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .char_fold (char_fold),
        .pat_flat  (pat_flat),
        .pat_len   (pat_len),
        .status    (status)
    );

    cis_text #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT),
        .LW          (LW)
    ) u_text (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .char_fold (char_fold),
        .pat_flat  (pat_flat),
        .pat_len   (pat_len),
        .status    (status),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign result_valid     = res_valid_reg;
    assign found            = res_reg.found;
    assign position         = res_reg.position;
    assign pattern_overflow = res_reg.overflow;

endmodule

// File: hw/rtl/cis_pattern.sv
// Pattern store, pattern length, open/closed tracking and overflow flag.
// Depends on cis_pkg.
`timescale 1ns / 1ps

module cis_pattern #(
    parameter int MAX_PATTERN = 16,
    parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cis_pkg::cis_ctl_t          ctl,
    input  logic [7:0]                 char_fold,
    output logic [MAX_PATTERN*8-1:0]   pat_flat,
    output logic [LW-1:0]              pat_len,
    output cis_pkg::cis_pat_status_t   status
);
    import cis_pkg::*;

    // Entry k holds the byte k places before the newest pattern byte, so
    // it lines up with window entry k at compare time.
    logic [7:0]    store_reg [MAX_PATTERN];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          closed_reg;
    logic          closed_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          restart;
    logic [LW-1:0] len_base;
    logic          ovf_base;
    logic          room;

    // A pattern byte that arrives after a closed pattern starts a new one.
    assign restart  = ctl.pat_beat & closed_reg;
    assign len_base = restart ? '0 : len_reg;
    assign ovf_base = restart ? 1'b0 : ovf_reg;
    assign room     = len_base < LW'(MAX_PATTERN);

    // Next-state logic for length, overflow and the closed flag.
    always_comb
    begin
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        closed_next = closed_reg;
        if (ctl.pat_beat)
        begin
            if (room)
            begin
                len_next = len_base + LW'(1);
                ovf_next = ovf_base;
            end
            else
            begin
                len_next = len_base;
                ovf_next = 1'b1;
            end
            closed_next = ctl.last_beat;
        end
        else if (ctl.txt_beat)
        begin
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b1;
        end
        else
        begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            closed_reg <= closed_next;
        end
    end

    // Pattern bytes shift in; bytes past the store depth are dropped.
    always_ff @(posedge clk)
    begin
        if (ctl.pat_beat && room)
        begin
            store_reg[0] <= char_fold;
            for (int k = 1; k < MAX_PATTERN; k++)
            begin
                store_reg[k] <= store_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_flat
        assign pat_flat[g*8 +: 8] = store_reg[g];
    end

    assign pat_len         = len_reg;
    assign status.restart  = restart;
    assign status.overflow = ovf_reg;

endmodule

// File: hw/rtl/cis_text.sv
// Text window, parallel compare against the pattern, first-match tracking
// and result formation. Depends on cis_pkg.
`timescale 1ns / 1ps

module cis_text #(
    parameter int              MAX_PATTERN = 16,
    parameter longint unsigned MAX_TEXT    = 65536,
    parameter int              LW          = $clog2(MAX_PATTERN + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cis_pkg::cis_ctl_t          ctl,
    input  logic [7:0]                 char_fold,
    input  logic [MAX_PATTERN*8-1:0]   pat_flat,
    input  logic [LW-1:0]              pat_len,
    input  cis_pkg::cis_pat_status_t   status,
    output logic                       res_valid,
    output cis_pkg::cis_result_t       res
);
    import cis_pkg::*;

    localparam int CW = $clog2(MAX_TEXT + 1);
    localparam int DW = (CW > LW) ? CW : LW;
    localparam int SW = (DW > POS_W + 1) ? DW : POS_W + 1;

    logic [7:0]       win_reg [MAX_PATTERN];
    logic [7:0]       win_new [MAX_PATTERN];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_inc;
    logic             seen_reg;
    logic [POS_W-1:0] start_reg;
    logic             all_eq;
    logic             long_enough;
    logic             take;
    logic [DW-1:0]    diff;
    logic [SW-1:0]    start_wide;
    logic [POS_W-1:0] start_sat;
    logic             seen_new;
    logic [POS_W-1:0] start_new;

    // Window as it stands once the current byte has shifted in.
    always_comb
    begin
        win_new[0] = char_fold;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            win_new[j] = win_reg[j-1];
        end
    end

    // The byte count saturates at the text limit.
    assign count_inc = (count_reg < CW'(MAX_TEXT)) ? count_reg + CW'(1) : count_reg;

    // Every window entry inside the pattern length must equal its pattern byte.
    always_comb
    begin
        all_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (j < int'(pat_len) && win_new[j] != pat_flat[j*8 +: 8])
            begin
                all_eq = 1'b0;
            end
        end
    end

    // First match: start index from the count, saturated to the port width.
    assign long_enough = DW'(count_inc) >= DW'(pat_len);
    assign take        = !seen_reg && !status.overflow && long_enough && all_eq;
    assign diff        = DW'(count_inc) - DW'(pat_len);
    assign start_wide  = SW'(diff);
    assign start_sat   = (start_wide > SW'(POS_MAX)) ? POS_MAX : start_wide[POS_W-1:0];
    assign seen_new    = seen_reg | take;
    assign start_new   = take ? start_sat : start_reg;

    // Result beat on the last text byte.
    assign res_valid    = ctl.txt_beat & ctl.last_beat;
    assign res.found    = !status.overflow & seen_new;
    assign res.position = (!status.overflow && seen_new) ? start_new : '0;
    assign res.overflow = status.overflow;

    // Count and match state; cleared at end of text and on a new pattern.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (ctl.txt_beat)
        begin
            if (ctl.last_beat)
            begin
                count_reg <= '0;
                seen_reg  <= 1'b0;
                start_reg <= '0;
            end
            else
            begin
                count_reg <= count_inc;
                seen_reg  <= seen_new;
                start_reg <= start_new;
            end
        end
        else if (status.restart)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
    end

    // Window shift. Only entries covered by the byte count are ever compared,
    // so stale bytes from an earlier text never matter.
    always_ff @(posedge clk)
    begin
        if (ctl.txt_beat)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                win_reg[j] <= win_new[j];
            end
        end
    end

endmodule

// File: hw/rtl/cis_checker.sv
// Port-level checks for the substring search block, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module cis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        command,
    input logic [7:0]  char_value,
    input logic        last,
    input logic        result_valid,
    input logic        result_ready,
    input logic        found,
    input logic [15:0] position,
    input logic        pattern_overflow
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(found) && $stable(position) && $stable(pattern_overflow))
        else $error("result payload changed while stalled");

    // With an empty result side the block always takes a new beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with no result pending");

    // An overflowed pattern never reports a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && pattern_overflow |-> !found && position == 16'd0)
        else $error("match reported for overflowed pattern");

    // No match means position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> position == 16'd0)
        else $error("nonzero position without a match");

endmodule

bind case_insensitive_substring_search cis_checker u_cis_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for case_insensitive_substring_search: a queue-fed driver,
// a monitor with a bit-accurate search predictor, and randomized handshake stalls.
// Depends on cis_pkg and the case_insensitive_substring_search RTL.
`timescale 1ns / 1ps

module testbench;

    import cis_pkg::*;

    localparam int          PAT_CAP      = 16;
    localparam int unsigned TEXT_CAP     = 65536;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SHOWN_ERRORS = 10;

    // One input beat waiting to be offered.
    typedef struct {
        logic       cmd;
        logic [7:0] data;
        logic       last_mark;
    } stim_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        command = CMD_PATTERN;
    logic [7:0]  char_value = 8'h00;
    logic        last = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        found;
    logic [15:0] position;
    logic        pattern_overflow;

    stim_beat_t  beat_queue [$];
    stim_beat_t  next_beat;
    cis_result_t search_results_due [$];

    int          beats_accepted = 0;
    int          results_checked = 0;
    int          found_count = 0;
    int          overflow_count = 0;
    int          error_count = 0;
    int          phase_two_start;
    int          phase_three_start;
    logic        hold_off = 1'b0;

    // Predictor state.
    logic [7:0]  pat_mem [PAT_CAP];
    int unsigned pat_len = 0;
    bit          pat_closed = 1'b1;
    bit          pat_over = 1'b0;
    logic [7:0]  win [PAT_CAP];
    int unsigned txt_cnt = 0;
    bit          hit_seen = 1'b0;
    logic [15:0] hit_pos = '0;

    case_insensitive_substring_search uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .command          (command),
        .char_value       (char_value),
        .last             (last),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .found            (found),
        .position         (position),
        .pattern_overflow (pattern_overflow)
    );

    always #5 clk = ~clk;

    // Idle phase from the number of accepted beats: 0, 1, or 2 for no idling.
    function automatic int idle_phase();
        if (beats_accepted < phase_two_start)
        begin
            return 0;
        end
        if (beats_accepted < phase_three_start)
        begin
            return 1;
        end
        return 2;
    endfunction

    function automatic int sender_gap_pct();
        case (idle_phase())
            0: return 14;
            1: return 86;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_gap_pct();
        case (idle_phase())
            0: return 86;
            1: return 14;
            default: return 0;
        endcase
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic add_beat(input logic cmd, input logic [7:0] data, input logic last_mark);
        stim_beat_t b;
        b.cmd = cmd;
        b.data = data;
        b.last_mark = last_mark;
        beat_queue.push_back(b);
    endtask

    // Mostly letters from a tiny alphabet so that matches are common.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 85)
        begin
            return 8'h61 + 8'($urandom_range(2));
        end
        return 8'($urandom_range(255));
    endfunction

    // Lower case letters are sent as upper case half the time.
    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1)
        begin
            return c & 8'hDF;
        end
        return c;
    endfunction

    // A well-formed session: one closed pattern, then a few texts that often hold it.
    task automatic add_session();
        logic [7:0] pat [20];
        logic [7:0] txt [30];
        int         plen;
        int         tlen;
        int         at;
        int         r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            plen = $urandom_range(20, PAT_CAP + 1);
        end
        else if (r < 25)
        begin
            plen = $urandom_range(PAT_CAP, 7);
        end
        else
        begin
            plen = $urandom_range(6, 1);
        end
        for (int k = 0; k < plen; k++)
        begin
            pat[k] = pick_char();
            add_beat(CMD_PATTERN, vary_case(pat[k]), k == plen - 1);
        end
        repeat ($urandom_range(4, 1))
        begin
            tlen = $urandom_range(30, 1);
            for (int k = 0; k < tlen; k++)
            begin
                txt[k] = pick_char();
            end
            if ($urandom_range(1) == 1 && plen <= tlen)
            begin
                at = $urandom_range(tlen - plen, 0);
                for (int k = 0; k < plen; k++)
                begin
                    txt[at + k] = pat[k];
                end
            end
            for (int k = 0; k < tlen; k++)
            begin
                add_beat(CMD_TEXT, vary_case(txt[k]), k == tlen - 1);
            end
        end
    endtask

    // Noise: a few beats with every field random, which also breaks sequences.
    task automatic add_noise();
        repeat ($urandom_range(6, 1))
        begin
            add_beat(1'($urandom_range(1)), 8'($urandom_range(255)),
                     $urandom_range(99) < 30);
        end
    endtask

    task automatic add_random(input int target);
        while (beat_queue.size() < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                add_session();
            end
            else
            begin
                add_noise();
            end
        end
    endtask

    task automatic clear_text_state();
        for (int i = 0; i < PAT_CAP; i++)
        begin
            win[i] = 8'h00;
        end
        txt_cnt = 0;
        hit_seen = 1'b0;
        hit_pos = '0;
    endtask

    // Advance the search state by one accepted beat and queue any result it causes.
    task automatic predict_search(input logic cmd, input logic [7:0] raw,
                                  input logic last_mark);
        logic [7:0]  ch;
        bit          same;
        int unsigned start;
        cis_result_t r;
        ch = raw;
        if (raw >= 8'h41 && raw <= 8'h5A)
        begin
            ch = raw | 8'h20;
        end
        if (cmd == CMD_PATTERN)
        begin
            // A pattern beat after a closed pattern starts a new one.
            if (pat_closed)
            begin
                pat_len = 0;
                pat_over = 1'b0;
                pat_closed = 1'b0;
                clear_text_state();
            end
            if (pat_len < PAT_CAP)
            begin
                pat_mem[pat_len] = ch;
                pat_len++;
            end
            else
            begin
                pat_over = 1'b1;
            end
            if (last_mark)
            begin
                pat_closed = 1'b1;
            end
        end
        else
        begin
            pat_closed = 1'b1;
            for (int i = PAT_CAP - 1; i > 0; i--)
            begin
                win[i] = win[i - 1];
            end
            win[0] = ch;
            if (txt_cnt < TEXT_CAP)
            begin
                txt_cnt++;
            end
            // Compare the newest window against the pattern until the first hit.
            if (!hit_seen && !pat_over && txt_cnt >= pat_len)
            begin
                same = 1'b1;
                for (int i = 0; i < pat_len; i++)
                begin
                    if (win[pat_len - 1 - i] != pat_mem[i])
                    begin
                        same = 1'b0;
                    end
                end
                if (same)
                begin
                    start = txt_cnt - pat_len;
                    hit_seen = 1'b1;
                    hit_pos = (start > 32'hFFFF) ? POS_MAX : start[15:0];
                end
            end
            if (last_mark)
            begin
                r.found = pat_over ? 1'b0 : hit_seen;
                r.position = (pat_over || !hit_seen) ? '0 : hit_pos;
                r.overflow = pat_over;
                search_results_due.push_back(r);
                clear_text_state();
            end
        end
    endtask

    // Driver: offers the next queued beat, holding it until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            command <= CMD_PATTERN;
            char_value <= 8'h00;
            last <= 1'b0;
        end
        else if (!item_valid || item_ready)
        begin
            if (beat_queue.size() > 0 && $urandom_range(99) >= sender_gap_pct())
            begin
                next_beat = beat_queue.pop_front();
                item_valid <= 1'b1;
                command <= next_beat.cmd;
                char_value <= next_beat.data;
                last <= next_beat.last_mark;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= !hold_off && ($urandom_range(99) >= receiver_gap_pct());
        end
    end

    // Monitor: feeds accepted beats to the predictor and checks result beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predict_search(command, char_value, last);
                beats_accepted <= beats_accepted + 1;
            end
            if (result_valid && result_ready)
            begin
                if (search_results_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected result found=%0d position=%0d overflow=%0d",
                                         found, position, pattern_overflow));
                end
                else
                begin
                    cis_result_t exp_r;
                    exp_r = search_results_due.pop_front();
                    if (found !== exp_r.found || position !== exp_r.position ||
                        pattern_overflow !== exp_r.overflow)
                    begin
                        flag_error($sformatf({"result %0d: expected found=%0d position=%0d ",
                                              "overflow=%0d, got found=%0d position=%0d ",
                                              "overflow=%0d"},
                                             results_checked, exp_r.found, exp_r.position,
                                             exp_r.overflow, found, position,
                                             pattern_overflow));
                    end
                    found_count += exp_r.found;
                    overflow_count += exp_r.overflow;
                end
                results_checked <= results_checked + 1;
            end
        end
    end

    // Long receiver hold-off at the start of the no-idle phase, while a burst of
    // one-byte texts is offered.
    initial
    begin
        @(posedge rst_n);
        while (beats_accepted < phase_three_start)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        // Empty pattern right after reset matches; its start index is the byte count, one.
        add_beat(CMD_TEXT, 8'h51, 1'b1);
        // Pattern at the edges of the fold range.
        add_beat(CMD_PATTERN, 8'h41, 1'b0);
        add_beat(CMD_PATTERN, 8'h5A, 1'b1);
        // Bytes just outside the fold range do not fold; match at three.
        add_beat(CMD_TEXT, 8'h40, 1'b0);
        add_beat(CMD_TEXT, 8'h5B, 1'b0);
        add_beat(CMD_TEXT, 8'hFF, 1'b0);
        add_beat(CMD_TEXT, 8'h61, 1'b0);
        add_beat(CMD_TEXT, 8'h5A, 1'b1);
        // Text shorter than the pattern.
        add_beat(CMD_TEXT, 8'h61, 1'b1);
        // Too long a pattern left open, then closed by a text beat.
        for (int k = 0; k < PAT_CAP + 1; k++)
        begin
            add_beat(CMD_PATTERN, 8'h00 + 8'(k * 15), 1'b0);
        end
        add_beat(CMD_TEXT, 8'h00, 1'b1);

        add_random(beat_queue.size() + 450);
        phase_two_start = beat_queue.size();
        add_random(beat_queue.size() + 450);
        phase_three_start = beat_queue.size();
        // Burst of one-byte texts to fill the block during the hold-off.
        repeat (24)
        begin
            add_beat(CMD_TEXT, vary_case(pick_char()), 1'b1);
        end
        add_random(beat_queue.size() + 430);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beat_queue.size() != 0 || item_valid || search_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (search_results_due.size() != 0)
        begin
            flag_error($sformatf("%0d expected results never arrived",
                                 search_results_due.size()));
        end
        $display("Checked %0d results (%0d found, %0d overflowed) from %0d input beats,",
                 results_checked, found_count, overflow_count, beats_accepted);
        $display("covering the empty pattern, case folding edges and a %0d-cycle result stall.",
                 HOLD_CYCLES);
        if (error_count > SHOWN_ERRORS)
        begin
            $display("%0d further errors not shown", error_count - SHOWN_ERRORS);
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #8_000_000;
        $display("Timeout: the run did not finish in time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
